>>> rtl/hbde_pkg.sv
package hbde_pkg;

  // field widths
  localparam int COL_CFG_W  = 9;
  localparam int ROW_CFG_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int PAIR_W     = 2 * RGB_W;
  localparam int THR_W      = 8;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int KIND_W     = 3;
  localparam int TOK_N      = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_ROW_COUNT = 1'b1;

  localparam logic [COL_CFG_W-1:0] COLUMN_COUNT_RST   = 9'd80;
  localparam logic [ROW_CFG_W-1:0] CELL_ROW_COUNT_RST = 7'd24;

  // request types
  localparam logic REQ_FRAME_START = 1'b0;
  localparam logic REQ_PIXEL_PAIR  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    TOK_CURSOR  = 3'd0,
    TOK_BG      = 3'd1,
    TOK_FG      = 3'd2,
    TOK_GLYPH   = 3'd3,
    TOK_NEWLINE = 3'd4
  } tok_kind_t;

  typedef enum logic [1:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SQ,
    CS_DEC
  } core_state_t;

  typedef struct packed {
    logic              req_type;
    logic [THR_W-1:0]  threshold;
    logic              clear_store;
    logic [CH_W-1:0]   top_red;
    logic [CH_W-1:0]   top_green;
    logic [CH_W-1:0]   top_blue;
    logic [CH_W-1:0]   bottom_red;
    logic [CH_W-1:0]   bottom_green;
    logic [CH_W-1:0]   bottom_blue;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    token_kind;
    logic [ROW_CFG_W-1:0] row;
    logic [COL_CFG_W-1:0] column;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic                 last;
  } out_item_t;

endpackage

>>> rtl/hbde_chan_if.sv
interface hbde_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/half_block_delta_color_encoder_unit.sv
// channel   dir  handshake                payload
// in_chan   in   valid/ready, sink        hbde_pkg::in_item_t (frame start or pixel pair)
// out_chan  out  valid/ready, source      hbde_pkg::out_item_t (one token per transaction)
// cfg_*     in   cfg_we, no back-pressure column_count (index 0), cell_row_count (index 1)
//
// a pixel pair passes through the core in a square stage (twelve 8x8 squares
// against the store entry and the current colors) and a decide stage that writes the store
// back; the emitter then sends its tokens one per cycle while out_chan is ready.
// after reset, and after a frame start with clear_store, a clearing pass writes black to all
// MAX_COLUMNS * MAX_CELL_ROWS entries of the store (16384 at defaults), with in_chan.ready low.
// a stalled out_chan backs up into the decide stage, then the input buffer, then in_chan.
module half_block_delta_color_encoder_unit #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_CELL_ROWS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hbde_chan_if.sink                        in_chan,
  hbde_chan_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [hbde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hbde_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CH_W    = hbde_pkg::CH_W;
  localparam int RGB_W   = hbde_pkg::RGB_W;
  localparam int PAIR_W  = hbde_pkg::PAIR_W;
  localparam int SQ_W    = hbde_pkg::SQ_W;
  localparam int DIST_W  = hbde_pkg::DIST_W;
  localparam int TOK_N   = hbde_pkg::TOK_N;
  localparam int COL_CW  = hbde_pkg::COL_CFG_W;
  localparam int ROW_CW  = hbde_pkg::ROW_CFG_W;

  localparam int DEPTH   = MAX_COLUMNS * MAX_CELL_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW      = (MAX_CELL_ROWS > 1) ? $clog2(MAX_CELL_ROWS) : 1;
  localparam int COL_LW  = ($clog2(MAX_COLUMNS + 1) > COL_CW) ? $clog2(MAX_COLUMNS + 1) : COL_CW;
  localparam int ROW_LW  = ($clog2(MAX_CELL_ROWS + 1) > ROW_CW) ?
                           $clog2(MAX_CELL_ROWS + 1) : ROW_CW;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_COLUMNS);

  // squared distance helpers
  function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    logic [SQ_W-1:0] dw;
    d  = (a > b) ? a - b : b - a;
    dw = SQ_W'(d);
    return dw * dw;
  endfunction

  function automatic logic [2:0][SQ_W-1:0] rgb_sq(input logic [RGB_W-1:0] a,
                                                  input logic [RGB_W-1:0] b);
    logic [2:0][SQ_W-1:0] s;
    for (int c = 0; c < 3; c++) begin
      s[c] = chan_sq(a[c*CH_W +: CH_W], b[c*CH_W +: CH_W]);
    end
    return s;
  endfunction

  function automatic logic [DIST_W-1:0] sum3(input logic [2:0][SQ_W-1:0] s);
    return DIST_W'(s[0]) + DIST_W'(s[1]) + DIST_W'(s[2]);
  endfunction

  // configuration registers
  logic [COL_CW-1:0] col_count_r;
  logic [ROW_CW-1:0] row_count_r;

  // front-end raster counters
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [COL_LW-1:0] cols_lim, col_inc, col_cfg_ext;
  logic [ROW_LW-1:0] rows_lim, row_inc, row_cfg_ext;
  logic end_row, last_row;
  logic [AW-1:0] in_idx;

  // input buffer
  logic              buf_v_r;
  logic              buf_frame_r;
  logic              buf_clr_r;
  logic [hbde_pkg::THR_W-1:0] buf_thr_r;
  logic [RGB_W-1:0]  buf_top_r, buf_bot_r;
  logic [AW-1:0]     buf_idx_r;
  logic [ROW_CW-1:0] buf_row1_r;
  logic [COL_CW-1:0] buf_col1_r;
  logic              buf_nl_r;

  // core item
  hbde_pkg::core_state_t state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [RGB_W-1:0]  it_top_r, it_bot_r;
  logic [AW-1:0]     it_idx_r;
  logic [ROW_CW-1:0] it_row1_r;
  logic [COL_CW-1:0] it_col1_r;
  logic              it_nl_r;

  // core state
  logic [RGB_W-1:0]  cur_bg_r, cur_bg_nxt;
  logic [RGB_W-1:0]  cur_fg_r, cur_fg_nxt;
  logic              skip_r, skip_nxt;
  logic [SQ_W-1:0]   thr_sq_r, thr_sq_nxt;

  // store and forwarding
  logic [PAIR_W-1:0] store_mem [DEPTH];
  logic [PAIR_W-1:0] rdata_r;
  logic              fwd_v_r;
  logic [PAIR_W-1:0] fwd_d_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [PAIR_W-1:0] mem_wd;
  logic [PAIR_W-1:0] old_pair;

  // square stage results
  logic [2:0][SQ_W-1:0] sq_ot_r, sq_ob_r, sq_bg_r, sq_fg_r;

  // decide stage
  logic mv_ot, mv_ob, mv_bg, mv_fg, changed;
  logic [RGB_W-1:0] new_bg, new_fg;
  logic [TOK_N-1:0] tok_mask;
  logic dec_fire, take, em_load;

  // token emitter
  logic [TOK_N-1:0]  em_mask_r, em_mask_nxt, em_rest;
  logic [ROW_CW-1:0] em_row_r;
  logic [COL_CW-1:0] em_col_r;
  logic [RGB_W-1:0]  em_bg_r, em_fg_r;
  logic              em_free, out_fire, in_fire, in_ready;
  hbde_pkg::tok_kind_t cur_kind;
  hbde_pkg::out_item_t out_d;

  //--------------------------------------------------------------------------
  // configuration writes
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= hbde_pkg::COLUMN_COUNT_RST;
      row_count_r <= hbde_pkg::CELL_ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hbde_pkg::REG_COLUMN_COUNT:   col_count_r <= cfg_data;
        hbde_pkg::REG_CELL_ROW_COUNT: row_count_r <= cfg_data[ROW_CW-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // raster position of the incoming pair; counters run ahead of the core
  //--------------------------------------------------------------------------
  always_comb begin
    col_cfg_ext = COL_LW'(col_count_r);
    row_cfg_ext = ROW_LW'(row_count_r);
    // saturate the programmed frame size to 1..max
    if (col_cfg_ext == '0) begin
      cols_lim = COL_LW'(1);
    end else if (col_cfg_ext > COL_LW'(MAX_COLUMNS)) begin
      cols_lim = COL_LW'(MAX_COLUMNS);
    end else begin
      cols_lim = col_cfg_ext;
    end
    if (row_cfg_ext == '0) begin
      rows_lim = ROW_LW'(1);
    end else if (row_cfg_ext > ROW_LW'(MAX_CELL_ROWS)) begin
      rows_lim = ROW_LW'(MAX_CELL_ROWS);
    end else begin
      rows_lim = row_cfg_ext;
    end
    col_inc  = COL_LW'(col_cnt_r) + COL_LW'(1);
    row_inc  = ROW_LW'(row_cnt_r) + ROW_LW'(1);
    end_row  = (col_inc >= cols_lim);
    last_row = (row_inc >= rows_lim);
    in_idx   = AW'(row_cnt_r) * ROW_STRIDE + AW'(col_cnt_r);
  end

  assign in_fire  = in_chan.valid && in_ready;
  assign out_fire = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      if (in_chan.data.req_type == hbde_pkg::REQ_FRAME_START) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end else if (end_row) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : RW'(row_inc);
      end else begin
        col_cnt_r <= CW'(col_inc);
      end
    end
  end

  //--------------------------------------------------------------------------
  // input buffer, one transaction deep
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
    end else if (in_fire) begin
      buf_v_r <= 1'b1;
    end else if (take) begin
      buf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf_frame_r <= (in_chan.data.req_type == hbde_pkg::REQ_FRAME_START);
      buf_clr_r   <= in_chan.data.clear_store;
      buf_thr_r   <= in_chan.data.threshold;
      buf_top_r   <= {in_chan.data.top_red, in_chan.data.top_green, in_chan.data.top_blue};
      buf_bot_r   <= {in_chan.data.bottom_red, in_chan.data.bottom_green,
                      in_chan.data.bottom_blue};
      buf_idx_r   <= in_idx;
      buf_row1_r  <= ROW_CW'(row_inc);
      buf_col1_r  <= COL_CW'(col_inc);
      // newline only at the end of a row that is not the last one
      buf_nl_r    <= end_row && !last_row;
    end
  end

  // no new transaction while the store is being cleared or about to be
  assign in_ready = (state_r != hbde_pkg::CS_CLEAR) && (!buf_v_r || take) &&
                    !(take && buf_frame_r && buf_clr_r);
  assign in_chan.ready = in_ready;

  //--------------------------------------------------------------------------
  // shown-pair store: read at the transfer into the core, written while clearing and in decide
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= store_mem[buf_idx_r];
  end

  // a write landing on the entry read in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= mem_we && (mem_wa == buf_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_d_r <= mem_wd;
  end

  assign old_pair = fwd_v_r ? fwd_d_r : rdata_r;

  //--------------------------------------------------------------------------
  // core sequencer
  //--------------------------------------------------------------------------
  assign em_rest = em_mask_r & (em_mask_r - TOK_N'(1));
  assign em_free = (em_mask_r == '0) || (out_fire && (em_rest == '0));

  // decide stage compares
  always_comb begin
    mv_ot   = sum3(sq_ot_r) > DIST_W'(thr_sq_r);
    mv_ob   = sum3(sq_ob_r) > DIST_W'(thr_sq_r);
    mv_bg   = sum3(sq_bg_r) > DIST_W'(thr_sq_r);
    mv_fg   = sum3(sq_fg_r) > DIST_W'(thr_sq_r);
    changed = mv_ot || mv_ob;
    new_bg  = mv_bg ? it_top_r : cur_bg_r;
    new_fg  = mv_fg ? it_bot_r : cur_fg_r;
    tok_mask = '0;
    tok_mask[hbde_pkg::TOK_CURSOR]  = skip_r;
    tok_mask[hbde_pkg::TOK_BG]      = mv_bg;
    tok_mask[hbde_pkg::TOK_FG]      = mv_fg;
    tok_mask[hbde_pkg::TOK_GLYPH]   = 1'b1;
    tok_mask[hbde_pkg::TOK_NEWLINE] = it_nl_r;
  end

  // next state
  always_comb begin
    case (state_r)
      hbde_pkg::CS_CLEAR: begin
        state_nxt = (clr_cnt_r == LAST_ADDR) ? hbde_pkg::CS_IDLE : hbde_pkg::CS_CLEAR;
      end
      hbde_pkg::CS_IDLE, hbde_pkg::CS_DEC: begin
        if (take) begin
          if (buf_frame_r) begin
            state_nxt = buf_clr_r ? hbde_pkg::CS_CLEAR : hbde_pkg::CS_IDLE;
          end else begin
            state_nxt = hbde_pkg::CS_SQ;
          end
        end else if (dec_fire) begin
          state_nxt = hbde_pkg::CS_IDLE;
        end else begin
          state_nxt = state_r;
        end
      end
      hbde_pkg::CS_SQ: begin
        state_nxt = hbde_pkg::CS_DEC;
      end
      default: begin
        state_nxt = hbde_pkg::CS_CLEAR;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    dec_fire    = 1'b0;
    take        = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = it_idx_r;
    mem_wd      = {new_bg, new_fg};
    clr_cnt_nxt = '0;
    case (state_r)
      hbde_pkg::CS_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      hbde_pkg::CS_IDLE: begin
        take = buf_v_r;
      end
      hbde_pkg::CS_DEC: begin
        // a pair that shows something waits for room in the emitter
        dec_fire = !changed || em_free;
        take     = buf_v_r && dec_fire;
        mem_we   = dec_fire && changed;
      end
      default: ;
    endcase
  end

  assign em_load = dec_fire && changed;

  // core state and emitter next values
  always_comb begin
    cur_bg_nxt  = cur_bg_r;
    cur_fg_nxt  = cur_fg_r;
    skip_nxt    = skip_r;
    thr_sq_nxt  = thr_sq_r;
    em_mask_nxt = em_mask_r;
    if (out_fire) begin
      em_mask_nxt = em_rest;
    end
    if (dec_fire) begin
      skip_nxt = !changed;
      if (changed) begin
        cur_bg_nxt  = new_bg;
        cur_fg_nxt  = new_fg;
        em_mask_nxt = tok_mask;
      end
    end
    // frame start comes after the pair in decide, so it wins
    if (take && buf_frame_r) begin
      cur_bg_nxt = '0;
      cur_fg_nxt = '0;
      skip_nxt   = 1'b1;
      thr_sq_nxt = SQ_W'(buf_thr_r) * SQ_W'(buf_thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= hbde_pkg::CS_CLEAR;
      clr_cnt_r <= '0;
      cur_bg_r  <= '0;
      cur_fg_r  <= '0;
      skip_r    <= 1'b1;
      thr_sq_r  <= '0;
      em_mask_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      cur_bg_r  <= cur_bg_nxt;
      cur_fg_r  <= cur_fg_nxt;
      skip_r    <= skip_nxt;
      thr_sq_r  <= thr_sq_nxt;
      em_mask_r <= em_mask_nxt;
    end
  end

  // item payload into the core
  always_ff @(posedge clk) begin
    if (take && !buf_frame_r) begin
      it_top_r  <= buf_top_r;
      it_bot_r  <= buf_bot_r;
      it_idx_r  <= buf_idx_r;
      it_row1_r <= buf_row1_r;
      it_col1_r <= buf_col1_r;
      it_nl_r   <= buf_nl_r;
    end
  end

  // square stage: store entry and current colors against the new pair
  always_ff @(posedge clk) begin
    if (state_r == hbde_pkg::CS_SQ) begin
      sq_ot_r <= rgb_sq(it_top_r, old_pair[PAIR_W-1:RGB_W]);
      sq_ob_r <= rgb_sq(it_bot_r, old_pair[RGB_W-1:0]);
      sq_bg_r <= rgb_sq(it_top_r, cur_bg_r);
      sq_fg_r <= rgb_sq(it_bot_r, cur_fg_r);
    end
  end

  //--------------------------------------------------------------------------
  // token emitter: pending tokens of one pair, lowest kind first
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (em_load) begin
      em_row_r <= it_row1_r;
      em_col_r <= it_col1_r;
      em_bg_r  <= it_top_r;
      em_fg_r  <= it_bot_r;
    end
  end

  always_comb begin
    if (em_mask_r[hbde_pkg::TOK_CURSOR]) begin
      cur_kind = hbde_pkg::TOK_CURSOR;
    end else if (em_mask_r[hbde_pkg::TOK_BG]) begin
      cur_kind = hbde_pkg::TOK_BG;
    end else if (em_mask_r[hbde_pkg::TOK_FG]) begin
      cur_kind = hbde_pkg::TOK_FG;
    end else if (em_mask_r[hbde_pkg::TOK_GLYPH]) begin
      cur_kind = hbde_pkg::TOK_GLYPH;
    end else begin
      cur_kind = hbde_pkg::TOK_NEWLINE;
    end
  end

  always_comb begin
    out_d            = '0;
    out_d.token_kind = cur_kind;
    out_d.last       = (em_rest == '0);
    case (cur_kind)
      hbde_pkg::TOK_CURSOR: begin
        out_d.row    = em_row_r;
        out_d.column = em_col_r;
      end
      hbde_pkg::TOK_BG: begin
        {out_d.red, out_d.green, out_d.blue} = em_bg_r;
      end
      hbde_pkg::TOK_FG: begin
        {out_d.red, out_d.green, out_d.blue} = em_fg_r;
      end
      default: ;
    endcase
  end

  assign out_chan.valid = (em_mask_r != '0);
  assign out_chan.data  = out_d;

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  a_em_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    em_load |-> (em_mask_r == '0) || (out_fire && $onehot(em_mask_r)))
    else $error("emitter reloaded with tokens pending");

  a_em_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !em_load) |=>
      ($countones(em_mask_r) == $countones($past(em_mask_r)) - 1))
    else $error("emitter dropped more than one token per transaction");

  a_store_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hbde_pkg::CS_SQ || state_r == hbde_pkg::CS_IDLE) |-> !mem_we)
    else $error("store written outside decide or clear");

  a_glyph_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> em_mask_r[hbde_pkg::TOK_GLYPH] ||
                       (em_mask_r[hbde_pkg::TOK_NEWLINE] && $onehot(em_mask_r)))
    else $error("token sent ahead of a missing glyph");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hbde_pkg::CS_CLEAR) |-> !(in_chan.valid && in_chan.ready))
    else $error("transaction accepted during store clear");

endmodule

>>> test/half_block_delta_color_encoder_unit_tb.sv
`timescale 1ns / 100ps

module half_block_delta_color_encoder_unit_tb;
  import hbde_pkg::*;

  localparam int MAX_COLS      = 256;
  localparam int MAX_ROWS      = 64;
  // core is two stages deep plus one token per cycle from the emitter while the sink is ready
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PAIRS  = 200;

  // predicts the token stream of the encoder and checks what comes out
  class token_ledger;
    logic [PAIR_W-1:0]    shown [MAX_COLS*MAX_ROWS];
    logic [RGB_W-1:0]     cur_bg;
    logic [RGB_W-1:0]     cur_fg;
    bit                   skipping;
    logic [THR_W-1:0]     thr;
    int                   row_ctr;
    int                   col_ctr;
    logic [COL_CFG_W-1:0] col_reg;
    logic [ROW_CFG_W-1:0] row_reg;
    out_item_t            expected_tokens[$];
    int                   errors;

    function new();
      foreach (shown[i]) shown[i] = '0;
      cur_bg   = '0;
      cur_fg   = '0;
      skipping = 1'b1;
      thr      = '0;
      row_ctr  = 0;
      col_ctr  = 0;
      col_reg  = COLUMN_COUNT_RST;
      row_reg  = CELL_ROW_COUNT_RST;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_COLUMN_COUNT) begin
        col_reg = data[COL_CFG_W-1:0];
      end else if (idx == REG_CELL_ROW_COUNT) begin
        row_reg = data[ROW_CFG_W-1:0];
      end
    endfunction

    function int eff_cols();
      if (col_reg == 0) return 1;
      if (int'(col_reg) > MAX_COLS) return MAX_COLS;
      return int'(col_reg);
    endfunction

    function int eff_rows();
      if (row_reg == 0) return 1;
      if (int'(row_reg) > MAX_ROWS) return MAX_ROWS;
      return int'(row_reg);
    endfunction

    function logic [PAIR_W-1:0] shown_here();
      return shown[(row_ctr % MAX_ROWS) * MAX_COLS + (col_ctr % MAX_COLS)];
    endfunction

    // squared rgb distance strictly above threshold squared
    function bit moved(logic [RGB_W-1:0] a, logic [RGB_W-1:0] b);
      int sq_sum;
      int d;
      sq_sum = 0;
      for (int k = 0; k < 3; k++) begin
        d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
        sq_sum += d * d;
      end
      return sq_sum > int'(thr) * int'(thr);
    endfunction

    function out_item_t make_token(tok_kind_t kind, int row, int col, logic [RGB_W-1:0] rgb);
      out_item_t t;
      t.token_kind = kind;
      t.row        = row[ROW_CFG_W-1:0];
      t.column     = col[COL_CFG_W-1:0];
      t.red        = rgb[23:16];
      t.green      = rgb[15:8];
      t.blue       = rgb[7:0];
      t.last       = 1'b0;
      return t;
    endfunction

    function void note_item(in_item_t it);
      out_item_t        toks [TOK_N];
      int               n;
      int               idx;
      bit               end_row;
      logic [RGB_W-1:0] top;
      logic [RGB_W-1:0] bot;
      logic [RGB_W-1:0] old_top;
      logic [RGB_W-1:0] old_bot;
      if (it.req_type == REQ_FRAME_START) begin
        thr      = it.threshold;
        if (it.clear_store) foreach (shown[i]) shown[i] = '0;
        cur_bg   = '0;
        cur_fg   = '0;
        skipping = 1'b1;
        row_ctr  = 0;
        col_ctr  = 0;
        return;
      end
      if (row_ctr >= MAX_ROWS) row_ctr = 0;
      if (col_ctr >= MAX_COLS) col_ctr = 0;
      top     = {it.top_red, it.top_green, it.top_blue};
      bot     = {it.bottom_red, it.bottom_green, it.bottom_blue};
      idx     = row_ctr * MAX_COLS + col_ctr;
      old_top = shown[idx][PAIR_W-1:RGB_W];
      old_bot = shown[idx][RGB_W-1:0];
      end_row = (col_ctr + 1 >= eff_cols());
      n = 0;
      if (!moved(top, old_top) && !moved(bot, old_bot)) begin
        skipping = 1'b1;
      end else begin
        if (skipping) begin
          toks[n] = make_token(TOK_CURSOR, row_ctr + 1, col_ctr + 1, '0);
          n++;
          skipping = 1'b0;
        end
        if (moved(top, cur_bg)) begin
          cur_bg  = top;
          toks[n] = make_token(TOK_BG, 0, 0, top);
          n++;
        end
        if (moved(bot, cur_fg)) begin
          cur_fg  = bot;
          toks[n] = make_token(TOK_FG, 0, 0, bot);
          n++;
        end
        toks[n] = make_token(TOK_GLYPH, 0, 0, '0);
        n++;
        if (end_row && row_ctr + 1 < eff_rows()) begin
          toks[n] = make_token(TOK_NEWLINE, 0, 0, '0);
          n++;
        end
        shown[idx] = {cur_bg, cur_fg};
      end
      if (end_row) begin
        col_ctr = 0;
        row_ctr = (row_ctr + 1 >= eff_rows()) ? 0 : row_ctr + 1;
      end else begin
        col_ctr++;
      end
      if (n > 0) toks[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) expected_tokens.push_back(toks[k]);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: kind %0d row %0d col %0d rgb %06h last %0b",
                   got.token_kind, got.row, got.column,
                   {got.red, got.green, got.blue}, got.last);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.row !== want.row ||
          got.column !== want.column || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t: expected kind %0d row %0d col %0d rgb %06h last %0b",
                   $realtime, want.token_kind, want.row, want.column,
                   {want.red, want.green, want.blue}, want.last);
          $display("                    got kind %0d row %0d col %0d rgb %06h last %0b",
                   got.token_kind, got.row, got.column,
                   {got.red, got.green, got.blue}, got.last);
        end
      end
    endfunction
  endclass

  // clock, reset and the signals the testbench drives
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic src_valid = 1'b0;
  in_item_t src_data = '0;
  logic sink_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hbde_chan_if #(.payload_t(in_item_t))  in_if ();
  hbde_chan_if #(.payload_t(out_item_t)) out_if ();

  assign in_if.valid  = src_valid;
  assign in_if.data   = src_data;
  assign out_if.ready = sink_ready;

  half_block_delta_color_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  token_ledger ledger;
  int burst_left = 0;
  int clears_left = 6;
  int pairs_sent = 0;
  logic [31:0] stall_pat = '1;
  int stall_age = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // guard against a hung handshake; worst case is far below this
  initial begin
    #14_400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // both transaction streams are observed at the rising edge, pre-update values
  always @(posedge clk) begin
    if (rst_n) begin
      if (src_valid && in_if.ready === 1'b1) ledger.note_item(src_data);
      if (out_if.valid === 1'b1 && sink_ready) ledger.check_token(out_if.data);
    end
  end

  // token receiver: rotates a stall pattern, swapping it for a new one now and then
  always @(negedge clk) begin
    if (stall_age == 0) begin
      sink_ready <= stall_pat[0];
      case ($urandom_range(0, 3))
        0:       stall_pat <= '1;                                      // no stalls at all
        1:       stall_pat <= ($urandom() & $urandom() & $urandom()) | 32'h1; // mostly stalled
        default: stall_pat <= $urandom() | 32'h1;
      endcase
      stall_age <= int'($urandom_range(16, 96));
    end else begin
      sink_ready <= stall_pat[0];
      stall_pat  <= {stall_pat[0], stall_pat[31:1]};
      stall_age  <= stall_age - 1;
    end
  end

  function automatic int clamp8(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // small random drift on every channel
  function automatic logic [RGB_W-1:0] drift(logic [RGB_W-1:0] c, int spread);
    logic [RGB_W-1:0] r;
    int v;
    for (int k = 0; k < 3; k++) begin
      v = int'(c[8*k +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
      r[8*k +: 8] = 8'(clamp8(v));
    end
    return r;
  endfunction

  // one channel pushed by exactly the threshold or one past it
  function automatic logic [RGB_W-1:0] at_threshold(logic [RGB_W-1:0] c);
    logic [RGB_W-1:0] r;
    int k;
    int amount;
    int v;
    r = c;
    k = int'($urandom_range(0, 2));
    amount = int'(ledger.thr) + int'($urandom_range(0, 1));
    v = int'(c[8*k +: 8]);
    v = (v + amount <= 255) ? v + amount : v - amount;
    r[8*k +: 8] = 8'(clamp8(v));
    return r;
  endfunction

  // most picks stay near what the cell shows or what is current, so skips and
  // suppressed color tokens come up often
  function automatic logic [RGB_W-1:0] pick_color(logic [RGB_W-1:0] seen,
                                                  logic [RGB_W-1:0] current);
    case ($urandom_range(0, 9))
      0, 1, 2: return seen;
      3:       return drift(seen, 3);
      4:       return at_threshold(seen);
      5:       return current;
      6: begin
        case ($urandom_range(0, 5))
          0:       return 24'h000000;
          1:       return 24'hFFFFFF;
          2:       return 24'hFF0000;
          3:       return 24'h00FF00;
          4:       return 24'h0000FF;
          default: return 24'h808080;
        endcase
      end
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'($urandom_range(1, 8));
      2:       return 8'($urandom_range(9, 40));
      3:       return 8'd128;
      4:       return 8'($urandom_range(129, 255));  // above the nominal range
      default: return 8'($urandom());
    endcase
  endfunction

  // fields that the request type does not use are filled with noise
  function automatic in_item_t frame_item(logic [THR_W-1:0] t, logic clr);
    in_item_t it;
    it.req_type     = REQ_FRAME_START;
    it.threshold    = t;
    it.clear_store  = clr;
    it.top_red      = 8'($urandom());
    it.top_green    = 8'($urandom());
    it.top_blue     = 8'($urandom());
    it.bottom_red   = 8'($urandom());
    it.bottom_green = 8'($urandom());
    it.bottom_blue  = 8'($urandom());
    return it;
  endfunction

  function automatic in_item_t pair_item(logic [RGB_W-1:0] top, logic [RGB_W-1:0] bot);
    in_item_t it;
    it.req_type    = REQ_PIXEL_PAIR;
    it.threshold   = 8'($urandom());
    it.clear_store = 1'($urandom());
    {it.top_red, it.top_green, it.top_blue}          = top;
    {it.bottom_red, it.bottom_green, it.bottom_blue} = bot;
    return it;
  endfunction

  // called at a falling edge; returns at the edge that takes the transaction
  task automatic offer(in_item_t it);
    src_valid <= 1'b1;
    src_data  <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_frame(logic [THR_W-1:0] t, logic clr);
    @(negedge clk);
    offer(frame_item(t, clr));
  endtask

  task automatic send_pair(logic [RGB_W-1:0] top, logic [RGB_W-1:0] bot);
    @(negedge clk);
    offer(pair_item(top, bot));
  endtask

  // sender bursts: random length, random gap, sometimes no gap
  task automatic keep_pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        @(negedge clk);
        src_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = int'($urandom_range(1, 16));
    end
    burst_left--;
  endtask

  task automatic send_random_pair();
    logic [PAIR_W-1:0] seen;
    keep_pace();
    @(negedge clk);
    // colors are chosen against what the ledger holds for the next cell
    seen = ledger.shown_here();
    offer(pair_item(pick_color(seen[PAIR_W-1:RGB_W], ledger.cur_bg),
                    pick_color(seen[RGB_W-1:0], ledger.cur_fg)));
  endtask

  // stop sending, let every pending token out, then cover skipped pairs still in flight
  task automatic drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (ledger.expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    ledger.write_reg(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one frame: new sizes while idle, a frame start, then pairs, maybe resized midway
  task automatic run_phase(int phase_no);
    int cols;
    int rows;
    int frame_size;
    int npairs;
    int split;
    bit clr;
    drain();
    case (phase_no)
      0: begin cols = 256; rows = 64;  end   // largest frame
      1: begin cols = 0;   rows = 0;   end   // below range, saturates to one
      2: begin cols = 511; rows = 127; end   // above range, saturates to max
      default: begin
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 4))
            0: cols = 0;
            1: cols = 1;
            2: cols = 256;
            3: cols = 257;
            default: cols = 511;
          endcase
          case ($urandom_range(0, 4))
            0: rows = 0;
            1: rows = 1;
            2: rows = 64;
            3: rows = 65;
            default: rows = 127;
          endcase
        end else begin
          cols = int'($urandom_range(1, 6));
          rows = int'($urandom_range(1, 4));
        end
      end
    endcase
    write_reg(REG_COLUMN_COUNT, 9'(cols));
    if (phase_no < 3 || $urandom_range(0, 3) != 0) write_reg(REG_CELL_ROW_COUNT, 9'(rows));
    frame_size = ledger.eff_cols() * ledger.eff_rows();

    // store clears cost a full clearing pass each, so they are rationed
    clr = (clears_left > 0 && $urandom_range(0, 5) == 0);
    if (clr) clears_left--;
    keep_pace();
    @(negedge clk);
    offer(frame_item(pick_threshold(), clr));

    npairs = (frame_size <= 24) ? int'($urandom_range(1, 2 * frame_size + 2))
                                : int'($urandom_range(3, 12));
    split  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, npairs)) : npairs + 1;
    for (int i = 0; i < npairs; i++) begin
      if (i == split) begin
        // resize in the middle of a frame
        drain();
        if ($urandom_range(0, 1) == 0)
          write_reg(REG_COLUMN_COUNT, 9'($urandom_range(1, 6)));
        else
          write_reg(REG_CELL_ROW_COUNT, 9'($urandom_range(1, 4)));
      end
      if ($urandom_range(0, 19) == 0) begin
        // stray frame start that breaks off the frame
        keep_pace();
        @(negedge clk);
        offer(frame_item(pick_threshold(), 1'b0));
      end
      send_random_pair();
      pairs_sent++;
    end
  endtask

  initial begin
    int phase_no;
    ledger = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, default sizes first; the first transaction waits out the clearing pass
    send_frame(8'd0, 1'b0);
    send_pair(24'hFFFFFF, 24'h000000);   // first cell: cursor, background, glyph
    send_pair(24'h000000, 24'h000000);   // matches the black store, skipped
    drain();
    write_reg(REG_COLUMN_COUNT, 9'd3);
    write_reg(REG_CELL_ROW_COUNT, 9'd2);
    send_frame(8'd0, 1'b0);
    send_pair(24'hFFFFFF, 24'hFFFFFF);   // only the lower pixel changed
    send_pair(24'h000000, 24'h000000);   // skipped
    send_pair(24'h00FF00, 24'h0000FF);   // all five tokens, newline ends row one
    send_pair(24'h123456, 24'hABCDEF);
    send_pair(24'h010203, 24'h040506);
    send_pair(24'h808080, 24'h7F7F7F);   // end of last row, no newline
    send_pair(24'hFFFFFF, 24'hFFFFFF);   // past the end, wraps to the first cell
    send_frame(8'd3, 1'b0);
    send_pair(24'hFFFFFC, 24'hFFFFFF);   // distance exactly at threshold, not moved
    send_pair(24'h000004, 24'h000000);   // one past threshold, moved
    send_frame(8'd255, 1'b0);            // threshold above 128
    send_pair(24'hFFFFFF, 24'h000000);
    send_frame(8'd128, 1'b1);            // clear the store
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'h000000);
    send_frame(8'd0, 1'b0);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h000000, 24'h000000);
    drain();
    write_reg(REG_COLUMN_COUNT, 9'd1);
    write_reg(REG_CELL_ROW_COUNT, 9'd1);
    send_frame(8'd0, 1'b0);
    send_pair(24'hFF00FF, 24'h00FF00);   // single cell frame, never a newline
    send_pair(24'hFF00FF, 24'h00FF00);   // same cell again, skipped
    send_pair(24'h000000, 24'hFFFFFF);

    // random frames until enough pairs have gone in
    phase_no = 0;
    while (pairs_sent < RANDOM_PAIRS) begin
      run_phase(phase_no);
      phase_no++;
    end

    drain();
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
